>>> rtl/core/idpd_pkg.sv
// ----------------------------------------------------------------------------
// idpd_pkg
// Shared types, constants and curve tables of the infrared distance PID drive.
// ----------------------------------------------------------------------------
package idpd_pkg;

   // register file indexes
   localparam logic [2:0] CSR_GAIN_P  = 3'd0;
   localparam logic [2:0] CSR_GAIN_I  = 3'd1;
   localparam logic [2:0] CSR_GAIN_D  = 3'd2;
   localparam logic [2:0] CSR_TARGET  = 3'd3;
   localparam logic [2:0] CSR_SAMPLE  = 3'd4;
   localparam logic [2:0] CSR_INVERSE = 3'd5;

   localparam logic signed [11:0] GAIN_P_RESET  = 12'sd256;
   localparam logic signed [11:0] GAIN_I_RESET  = 12'sd0;
   localparam logic signed [11:0] GAIN_D_RESET  = 12'sd0;
   localparam logic [6:0]         TARGET_RESET  = 7'd15;
   localparam logic [15:0]        SAMPLE_RESET  = 16'd2139;
   localparam logic [15:0]        INVERSE_RESET = 16'd7843;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // curve segment codes
   localparam logic [2:0] SEG_NEAR = 3'd0;
   localparam logic [2:0] SEG_A    = 3'd1;
   localparam logic [2:0] SEG_B    = 3'd2;
   localparam logic [2:0] SEG_C    = 3'd3;
   localparam logic [2:0] SEG_D    = 3'd4;
   localparam logic [2:0] SEG_E    = 3'd5;
   localparam logic [2:0] SEG_FAR  = 3'd6;

   localparam logic [6:0] DIST_NEAR = 7'd10;
   localparam logic [6:0] DIST_FAR  = 7'd75;

   typedef struct packed {
      logic signed [11:0] gain_p;
      logic signed [11:0] gain_i;
      logic signed [11:0] gain_d;
      logic [6:0]         target_distance;
      logic [15:0]        sample_interval;
      logic [15:0]        inverse_interval;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [9:0]  slope;
      logic [14:0] offset;
   } coef_type;

   function automatic logic [2:0] seg_classify(input logic [7:0] level);
      logic [2:0] seg;
      if (level > 8'd132)     seg = SEG_NEAR;
      else if (level > 8'd91) seg = SEG_A;
      else if (level > 8'd70) seg = SEG_B;
      else if (level > 8'd49) seg = SEG_C;
      else if (level > 8'd37) seg = SEG_D;
      else if (level > 8'd22) seg = SEG_E;
      else                    seg = SEG_FAR;
      return seg;
   endfunction

   // slope magnitude in unsigned Q2.8 and offset in unsigned Q7.8
   function automatic coef_type seg_coef(input logic [2:0] seg);
      coef_type c;
      case (seg)
         SEG_A:   c = '{slope: 10'd31,  offset: 15'd6682};
         SEG_B:   c = '{slope: 10'd61,  offset: 15'd9388};
         SEG_C:   c = '{slope: 10'd123, offset: 15'd13652};
         SEG_D:   c = '{slope: 10'd212, offset: 15'd18132};
         SEG_E:   c = '{slope: 10'd512, offset: 15'd29184};
         default: c = '{slope: 10'd0,   offset: 15'd0};
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/idpd_front.sv
// ----------------------------------------------------------------------------
// idpd_front
// Accepts sensor levels, classifies the curve segment and converts to cm.
// ----------------------------------------------------------------------------
module idpd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_level,
   output logic                      q_push,
   output logic [6:0]                q_data,
   input  idpd_pkg::queue_status_type q_status
);
   import idpd_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] level_ff;
   logic [2:0] seg_ff;
   coef_type   coef;
   logic [17:0] slope_prod;
   logic [17:0] curve_val;
   logic        accept;

   assign req_tready = !stage_valid_ff || !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = stage_valid_ff && !q_status.full;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (q_push) stage_valid_in = 1'b0;
      if (accept) stage_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         level_ff <= req_level;
         seg_ff   <= seg_classify(req_level);
      end
   end

   // offset - slope * level is never negative inside its segment
   assign coef       = seg_coef(seg_ff);
   assign slope_prod = coef.slope * level_ff;
   assign curve_val  = {3'b000, coef.offset} - slope_prod;

   always_comb begin
      case (seg_ff)
         SEG_NEAR: q_data = DIST_NEAR;
         SEG_FAR:  q_data = DIST_FAR;
         default:  q_data = curve_val[14:8];
      endcase
   end

endmodule

>>> rtl/core/idpd_queue.sv
// ----------------------------------------------------------------------------
// idpd_queue
// Short queue of converted distances between the front and back ends.
// ----------------------------------------------------------------------------
module idpd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [6:0]                 push_data,
   input  logic                       pop,
   output logic [6:0]                 head_data,
   output idpd_pkg::queue_status_type status
);
   import idpd_pkg::*;

   logic [6:0]             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/idpd_back.sv
// ----------------------------------------------------------------------------
// idpd_back
// PID sequencer: error, integral, derivative and gain products on one shared
// multiplier, then saturation, drive mapping and the result register.
// ----------------------------------------------------------------------------
module idpd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  idpd_pkg::cfg_type          cfg,
   input  idpd_pkg::queue_status_type q_status,
   input  logic [6:0]                 q_head,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata
);
   import idpd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INT  = 3'd1;
   localparam logic [2:0] S_SAT  = 3'd2;
   localparam logic [2:0] S_DRV  = 3'd3;
   localparam logic [2:0] S_AC1  = 3'd4;
   localparam logic [2:0] S_AC2  = 3'd5;
   localparam logic [2:0] S_AC3  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   localparam int ACC_W = 46;

   logic [2:0]         state_ff, state_in;
   logic signed [7:0]  prev_err_ff;
   logic signed [23:0] integral_ff;
   logic signed [7:0]  err_ff;
   logic signed [8:0]  diff_ff;
   logic [6:0]         dist_ff;
   logic signed [41:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   logic signed [7:0]  err_new;
   logic signed [24:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [41:0] prod_in;
   logic signed [26:0] integ_sum;
   logic signed [23:0] integ_sat;
   logic signed [ACC_W-1:0] prod_ext;
   logic signed [21:0] quot;
   logic signed [7:0]  sum_sat;
   logic [7:0]         sum_mag;
   logic [6:0]         drive;
   logic               out_free;
   logic               out_load;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == S_OUT) && out_free;
   assign q_pop    = (state_ff == S_IDLE) && !q_status.empty;

   assign err_new = $signed({1'b0, cfg.target_distance}) - $signed({1'b0, q_head});

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_INT: begin
            mul_a = 25'(err_ff);
            mul_b = $signed({1'b0, cfg.sample_interval});
         end
         S_SAT: begin
            mul_a = 25'(diff_ff);
            mul_b = $signed({1'b0, cfg.inverse_interval});
         end
         S_DRV: begin
            mul_a = prod_ff[24:0];
            mul_b = 17'(cfg.gain_d);
         end
         S_AC1: begin
            mul_a = 25'(integral_ff);
            mul_b = 17'(cfg.gain_i);
         end
         S_AC2: begin
            mul_a = 25'(err_ff);
            mul_b = 17'(cfg.gain_p);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);

   assign integ_sum = 27'(integral_ff) + 27'($signed(prod_ff[25:0]));
   always_comb begin
      if (integ_sum[26:23] == 4'b0000 || integ_sum[26:23] == 4'b1111) begin
         integ_sat = integ_sum[23:0];
      end else if (integ_sum[26]) begin
         integ_sat = 24'sh800000;
      end else begin
         integ_sat = 24'sh7FFFFF;
      end
   end

   // divide by 2^24 toward zero, then clamp
   always_comb begin
      quot = acc_ff[ACC_W-1:24];
      if (acc_ff[ACC_W-1] && (acc_ff[23:0] != '0)) quot = quot + 22'sd1;
      if (quot > 22'sd127)       sum_sat = 8'sd127;
      else if (quot < -22'sd128) sum_sat = -8'sd128;
      else                       sum_sat = quot[7:0];
      sum_mag = sum_sat[7] ? 8'(-sum_sat) : sum_sat;
      drive   = (sum_mag > 8'd30) ? 7'd80 : 7'(sum_mag + 8'd50);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (q_pop) state_in = S_INT;
         S_INT:   state_in = S_SAT;
         S_SAT:   state_in = S_DRV;
         S_DRV:   state_in = S_AC1;
         S_AC1:   state_in = S_AC2;
         S_AC2:   state_in = S_AC3;
         S_AC3:   state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_err_ff  <= '0;
         integral_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop) prev_err_ff <= err_new;
         if (state_ff == S_SAT) integral_ff <= integ_sat;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (q_pop) begin
         err_ff  <= err_new;
         diff_ff <= 9'(err_new) - 9'(prev_err_ff);
         dist_ff <= q_head;
      end
      case (state_ff)
         S_AC1:   acc_ff <= prod_ext <<< 8;
         S_AC2:   acc_ff <= acc_ff + prod_ext;
         S_AC3:   acc_ff <= acc_ff + (prod_ext <<< 16);
         default: acc_ff <= acc_ff;
      endcase
      if (out_load) begin
         rsp_data_ff <= {2'b00, drive, sum_sat, err_ff, dist_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("result load did not raise rsp_tvalid");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !out_free) |=> state_ff == S_OUT)
      else $error("sequencer left output state without loading");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !q_pop)
      else $error("queue popped while sequencer busy");
`endif

endmodule

>>> rtl/core/ir_distance_pid_drive.sv
// ----------------------------------------------------------------------------
// ir_distance_pid_drive
// Infrared wall-distance sensor to PID motor drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 8-bit sensor level per transaction (req_tdata[7:0]).
//   rsp_*  : one result per sample: distance, error, saturated PID sum and
//            motor drive, packed in rsp_tdata.
//   csr_*  : register writes (index 0..5), always ready; write only while
//            no sample is in flight. Indexes 6 and 7 are ignored.
// Path: an accepted sample passes the front end (curve lookup and multiply),
//   the queue and the PID sequencer (queue pop, six multiply and accumulate
//   steps, output), which shares one 25x17 multiplier over five products.
// Flow: the sequencer works on one sample at a time and pops the next only
//   from its idle step; the two-entry queue lets the front end take up to
//   three samples ahead of it.
// Reset: registers return to their defaults, the integral and previous error
//   clear, the queue empties and no result is pending.
// Stall: a result held on rsp_* stays until taken; the sequencer then waits
//   in its output step, the queue fills and req_tready drops.
// ----------------------------------------------------------------------------
module ir_distance_pid_drive (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] sensor_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] distance_cm, [14:7] distance_error,
                                    // [22:15] control_sum, [29:23] motor_drive
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import idpd_pkg::*;

   cfg_type          cfg_ff;
   queue_status_type q_status;
   logic             q_push, q_pop;
   logic [6:0]       q_in_data, q_head;
   logic             csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p           <= GAIN_P_RESET;
         cfg_ff.gain_i           <= GAIN_I_RESET;
         cfg_ff.gain_d           <= GAIN_D_RESET;
         cfg_ff.target_distance  <= TARGET_RESET;
         cfg_ff.sample_interval  <= SAMPLE_RESET;
         cfg_ff.inverse_interval <= INVERSE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN_P:  cfg_ff.gain_p           <= $signed(csr_data[11:0]);
            CSR_GAIN_I:  cfg_ff.gain_i           <= $signed(csr_data[11:0]);
            CSR_GAIN_D:  cfg_ff.gain_d           <= $signed(csr_data[11:0]);
            CSR_TARGET:  cfg_ff.target_distance  <= csr_data[6:0];
            CSR_SAMPLE:  cfg_ff.sample_interval  <= csr_data;
            CSR_INVERSE: cfg_ff.inverse_interval <= csr_data;
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

   idpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_level  (req_tdata),
      .q_push     (q_push),
      .q_data     (q_in_data),
      .q_status   (q_status)
   );

   idpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head_data (q_head),
      .status    (q_status)
   );

   idpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ir_distance_pid_drive. Sensor levels go in on the
// req_* stream and the registers change between phases through csr_*. Each
// accepted level is run through a local copy of the curve, the PID state and
// the drive rule. Every rsp_* transaction is checked field by field against
// the oldest predicted drive result. The sender works in random bursts and
// the receiver stalls in random modes.
// ----------------------------------------------------------------------------
module testbench;
   import idpd_pkg::*;

   // indexes past the register list, which the block must ignore
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   localparam longint INTEGRAL_TOP    = 64'sd8388607;
   localparam longint INTEGRAL_BOTTOM = -64'sd8388608;
   localparam longint SUM_SCALE       = 64'sd16777216;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE
   } ready_mode_type;

   typedef struct packed {
      logic [7:0]         sensor_level;
      logic [6:0]         distance_cm;
      logic signed [7:0]  distance_error;
      logic signed [7:0]  control_sum;
      logic [6:0]         motor_drive;
   } drive_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = 3'd0;
   logic [15:0] csr_data   = 16'd0;

   // local copy of the register file and the controller state
   cfg_type     regs_copy;
   int          last_error;
   int          integral_acc;

   drive_result_type pending_drive[$];
   int unsigned      mismatch_count = 0;
   int unsigned      burst_left     = 0;
   int unsigned      hold_cycles_req = 0;

   ir_distance_pid_drive uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic int sensor_curve_cm(input logic [7:0] level);
      int slope;
      int offset;
      if (level > 8'd132) begin
         return 10;
      end else if (level > 8'd91) begin
         slope = 31;  offset = 6682;
      end else if (level > 8'd70) begin
         slope = 61;  offset = 9388;
      end else if (level > 8'd49) begin
         slope = 123; offset = 13652;
      end else if (level > 8'd37) begin
         slope = 212; offset = 18132;
      end else if (level > 8'd22) begin
         slope = 512; offset = 29184;
      end else begin
         return 75;
      end
      return (offset - slope * int'(level)) >> 8;
   endfunction

   function automatic drive_result_type predict_drive(input logic [7:0] level);
      drive_result_type r;
      int     distance;
      int     err;
      longint deriv;
      longint integ;
      longint total;
      longint q;
      longint mag;
      distance = sensor_curve_cm(level);
      err   = int'(regs_copy.target_distance) - distance;
      deriv = longint'(err - last_error) * longint'(regs_copy.inverse_interval);
      integ = longint'(integral_acc) + longint'(err) * longint'(regs_copy.sample_interval);
      if (integ > INTEGRAL_TOP) integ = INTEGRAL_TOP;
      if (integ < INTEGRAL_BOTTOM) integ = INTEGRAL_BOTTOM;
      integral_acc = int'(integ);
      total = longint'(regs_copy.gain_p) * longint'(err) * 64'sd65536
            + longint'(regs_copy.gain_i) * integ
            + longint'(regs_copy.gain_d) * deriv * 64'sd256;
      // signed division truncates toward zero
      q = total / SUM_SCALE;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      mag = (q < 0) ? -q : q;
      last_error = err;
      r.sensor_level   = level;
      r.distance_cm    = 7'(distance);
      r.distance_error = 8'(err);
      r.control_sum    = 8'(q);
      r.motor_drive    = (mag > 30) ? 7'd80 : 7'(mag + 50);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      drive_result_type want;
      drive_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.distance_cm    = rsp_tdata[6:0];
         got.distance_error = rsp_tdata[14:7];
         got.control_sum    = rsp_tdata[22:15];
         got.motor_drive    = rsp_tdata[29:23];
         if (pending_drive.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: dist %0d err %0d sum %0d drive %0d",
                        got.distance_cm, got.distance_error, got.control_sum,
                        got.motor_drive);
            mismatch_count++;
         end else begin
            want = pending_drive.pop_front();
            if (got.distance_cm != want.distance_cm
                || got.distance_error != want.distance_error
                || got.control_sum != want.control_sum
                || got.motor_drive != want.motor_drive) begin
               if (mismatch_count < 10)
                  $display({"mismatch level %0d: expected dist %0d err %0d sum %0d",
                            " drive %0d, got dist %0d err %0d sum %0d drive %0d"},
                           want.sensor_level, want.distance_cm, want.distance_error,
                           want.control_sum, want.motor_drive, got.distance_cm,
                           got.distance_error, got.control_sum, got.motor_drive);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random ready modes, plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      ready_mode_type ready_mode;
      int unsigned    mode_left;
      int unsigned    stall_count;
      ready_mode = READY_ALWAYS;
      mode_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles_req != 0) begin
            rsp_tready <= 1'b0;
            stall_count = hold_cycles_req;
            hold_cycles_req = 0;
            while (stall_count != 0) begin
               @(posedge clock);
               stall_count--;
            end
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 2));
               mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (ready_mode)
               READY_ALWAYS: begin
                  rsp_tready <= 1'b1;
               end
               READY_COIN: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // shared driving tasks
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic [7:0] level);
      int unsigned gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(10, 24);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= level;
      do @(posedge clock); while (!req_tready);
      pending_drive.push_back(predict_drive(level));
   endtask

   // stop sending and hold until every predicted result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_drive.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_GAIN_P:  regs_copy.gain_p           = value[11:0];
         CSR_GAIN_I:  regs_copy.gain_i           = value[11:0];
         CSR_GAIN_D:  regs_copy.gain_d           = value[11:0];
         CSR_TARGET:  regs_copy.target_distance  = value[6:0];
         CSR_SAMPLE:  regs_copy.sample_interval  = value;
         CSR_INVERSE: regs_copy.inverse_interval = value;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] random_gain();
      int g;
      case ($urandom_range(0, 5))
         0:       return 16'h0800;
         1:       return 16'h07FF;
         2:       return 16'($urandom_range(0, 65535));
         default: begin
            g = int'($urandom_range(0, 1023)) - 512;
            return 16'(g);
         end
      endcase
   endfunction

   function automatic logic [15:0] random_target();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd75;
         2:       return 16'($urandom_range(76, 127));
         3:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 75));
      endcase
   endfunction

   function automatic logic [15:0] random_interval();
      case ($urandom_range(0, 4))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 8191));
      endcase
   endfunction

   function automatic logic [7:0] random_level();
      logic [7:0] edges [12];
      edges = '{8'd22, 8'd23, 8'd37, 8'd38, 8'd49, 8'd50,
                8'd70, 8'd71, 8'd91, 8'd92, 8'd132, 8'd133};
      if ($urandom_range(0, 3) == 0)
         return edges[$urandom_range(0, 11)];
      return 8'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_curve_points();
      logic [7:0] points [14];
      points = '{8'd0, 8'd22, 8'd23, 8'd37, 8'd38, 8'd49, 8'd50,
                 8'd70, 8'd71, 8'd91, 8'd92, 8'd132, 8'd133, 8'd255};
      foreach (points[k]) send_sample(points[k]);
      drain_results();
   endtask

   task automatic test_register_extremes();
      // indexes past the list must leave the registers alone
      write_reg(CSR_SPARE_6, 16'hFFFF);
      write_reg(CSR_SPARE_7, 16'h5A5A);
      csr_valid <= 1'b0;
      send_sample(8'd60);
      drain_results();
      // large proportional gain: sum saturates high, then low
      write_reg(CSR_GAIN_P, 16'h07FF);
      write_reg(CSR_TARGET, 16'd75);
      csr_valid <= 1'b0;
      send_sample(8'd255);
      send_sample(8'd0);
      drain_results();
      write_reg(CSR_GAIN_P, 16'h0800);
      csr_valid <= 1'b0;
      send_sample(8'd255);
      drain_results();
      // target above the curve range, integral runs into its limit
      write_reg(CSR_GAIN_P, 16'd0);
      write_reg(CSR_GAIN_I, 16'h07FF);
      write_reg(CSR_TARGET, 16'd127);
      write_reg(CSR_SAMPLE, 16'hFFFF);
      csr_valid <= 1'b0;
      repeat (3) send_sample(8'd255);
      drain_results();
      // largest derivative swings
      write_reg(CSR_GAIN_I, 16'd0);
      write_reg(CSR_GAIN_D, 16'h07FF);
      write_reg(CSR_INVERSE, 16'hFFFF);
      csr_valid <= 1'b0;
      send_sample(8'd0);
      send_sample(8'd255);
      drain_results();
      write_reg(CSR_TARGET, 16'd0);
      write_reg(CSR_SAMPLE, 16'd0);
      write_reg(CSR_INVERSE, 16'd0);
      csr_valid <= 1'b0;
      send_sample(8'd200);
      drain_results();
   endtask

   task automatic test_backpressure();
      write_reg(CSR_GAIN_P, 16'd256);
      write_reg(CSR_TARGET, 16'd30);
      csr_valid <= 1'b0;
      // long receiver hold while the sender keeps offering
      hold_cycles_req = 120;
      burst_left = 24;
      repeat (24) send_sample(random_level());
      drain_results();
   endtask

   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned phase_len;
      sent = 0;
      while (sent < 500) begin
         drain_results();
         if ($urandom_range(0, 1)) write_reg(CSR_GAIN_P, random_gain());
         if ($urandom_range(0, 1)) write_reg(CSR_GAIN_I, random_gain());
         if ($urandom_range(0, 1)) write_reg(CSR_GAIN_D, random_gain());
         if ($urandom_range(0, 1)) write_reg(CSR_TARGET, random_target());
         if ($urandom_range(0, 1)) write_reg(CSR_SAMPLE, random_interval());
         if ($urandom_range(0, 1)) write_reg(CSR_INVERSE, random_interval());
         if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE_6, 16'($urandom_range(0, 65535)));
         if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE_7, 16'($urandom_range(0, 65535)));
         csr_valid <= 1'b0;
         phase_len = $urandom_range(15, 60);
         repeat (phase_len) send_sample(random_level());
         sent += phase_len;
      end
      drain_results();
   endtask

   initial begin
      regs_copy.gain_p           = GAIN_P_RESET;
      regs_copy.gain_i           = GAIN_I_RESET;
      regs_copy.gain_d           = GAIN_D_RESET;
      regs_copy.target_distance  = TARGET_RESET;
      regs_copy.sample_interval  = SAMPLE_RESET;
      regs_copy.inverse_interval = INVERSE_RESET;
      last_error   = 0;
      integral_acc = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_curve_points();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      // let any stray result show up before the verdict
      repeat (30) @(posedge clock);
      if (pending_drive.size() != 0) begin
         $display("%0d results never arrived", pending_drive.size());
         mismatch_count += pending_drive.size();
      end
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
